// ===== rtl/mlcp_pkg.sv =====
// shared types, constants and helpers for the multiplexed led cube pwm driver
package mlcp_pkg;

	// cube geometry
	localparam int LAYER_COUNT  = 3;
	localparam int COLUMN_COUNT = 9;

	// active layer register width, wide enough to hold the reset layer of 2
	localparam int ACT_W = ($clog2(LAYER_COUNT) > 2) ? $clog2(LAYER_COUNT) : 2;

	// reset layer and counter start
	localparam logic [ACT_W-1:0] LAYER_RESET = ACT_W'(2);
	localparam logic [7:0]       COUNT_RESET = 8'd255;

	// request codes
	typedef enum logic {
		REQ_TICK  = 1'b0,
		REQ_WRITE = 1'b1
	} mlcp_req_t;

	// input beat
	typedef struct packed {
		mlcp_req_t  req_type;
		logic [1:0] layer_sel;
		logic [3:0] column_sel;
		logic [7:0] brightness_value;
	} mlcp_in_t;

	// result beat
	typedef struct packed {
		logic [8:0] column_pins;
		logic [2:0] layer_pins;
	} mlcp_out_t;

	// brightness held by each layer after reset
	function automatic logic [7:0] reset_level(input int layer);
		logic [7:0] lvl;
		case (layer)
			0:       lvl = 8'd0;
			1:       lvl = 8'd125;
			default: lvl = 8'd200;
		endcase
		return lvl;
	endfunction

endpackage

// ===== rtl/mlcp_engine.sv =====
// pwm state, brightness store and the per-tick update
module mlcp_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  mlcp_pkg::mlcp_in_t  item,
	output mlcp_pkg::mlcp_out_t result
);
	import mlcp_pkg::*;

	logic [7:0]              store_q  [LAYER_COUNT][COLUMN_COUNT];
	logic [7:0]              shadow_q [COLUMN_COUNT];
	logic [7:0]              count_q;
	logic [ACT_W-1:0]        layer_q;
	logic [COLUMN_COUNT-1:0] mask_q;
	logic [LAYER_COUNT-1:0]  cathode_q;

	logic                    tick;
	logic                    wr;
	logic [7:0]              count_d;
	logic                    wrap;
	logic [ACT_W:0]          layer_sum;
	logic [ACT_W-1:0]        layer_step;
	logic [7:0]              row      [COLUMN_COUNT];
	logic [7:0]              shadow_d [COLUMN_COUNT];
	logic [COLUMN_COUNT-1:0] mask_d;
	logic [LAYER_COUNT-1:0]  cath_wrap;
	logic [LAYER_COUNT-1:0]  cathode_d;
	logic [63:0]             mask_wide;
	logic [7:0]              cath_wide;

	assign tick = step && (item.req_type == REQ_TICK);
	assign wr   = step && (item.req_type == REQ_WRITE);

	// counter advance and layer step, a stale layer goes to layer 0
	always_comb begin
		count_d   = count_q + 8'd1;
		wrap      = (count_d == 8'd0);
		layer_sum = {1'b0, layer_q} + (ACT_W+1)'(1);
		if (layer_sum >= (ACT_W+1)'(LAYER_COUNT)) begin
			layer_step = '0;
		end else begin
			layer_step = layer_sum[ACT_W-1:0];
		end
	end

	// row of the new layer and cathode levels at a wrap
	always_comb begin
		for (int c = 0; c < COLUMN_COUNT; c++) begin
			row[c] = '0;
		end
		cath_wrap = cathode_q;
		for (int k = 0; k < LAYER_COUNT; k++) begin
			if (layer_step == ACT_W'(k)) begin
				for (int c = 0; c < COLUMN_COUNT; c++) begin
					row[c] = store_q[k][c];
				end
			end
			if (layer_q == ACT_W'(k)) begin
				cath_wrap[k] = 1'b1;
			end
		end
		for (int k = 0; k < LAYER_COUNT; k++) begin
			if (layer_step == ACT_W'(k)) begin
				cath_wrap[k] = 1'b0;
			end
		end
		cathode_d = wrap ? cath_wrap : cathode_q;
	end

	// column compare against the new count
	always_comb begin
		mask_d = wrap ? '1 : mask_q;
		for (int c = 0; c < COLUMN_COUNT; c++) begin
			shadow_d[c] = wrap ? row[c] : shadow_q[c];
			if (shadow_d[c] == count_d) begin
				mask_d[c] = 1'b0;
			end
		end
	end

	// result: mask from before the tick, cathodes after it
	always_comb begin
		mask_wide          = 64'(mask_q);
		cath_wide          = 8'(cathode_d);
		result.column_pins = mask_wide[8:0];
		result.layer_pins  = cath_wide[2:0];
	end

	// pwm state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= COUNT_RESET;
			layer_q   <= LAYER_RESET;
			mask_q    <= '1;
			cathode_q <= '1;
			for (int c = 0; c < COLUMN_COUNT; c++) begin
				shadow_q[c] <= '0;
			end
		end else if (tick) begin
			count_q   <= count_d;
			mask_q    <= mask_d;
			cathode_q <= cathode_d;
			if (wrap) begin
				layer_q <= layer_step;
			end
			for (int c = 0; c < COLUMN_COUNT; c++) begin
				shadow_q[c] <= shadow_d[c];
			end
		end
	end

	// brightness store, out of range writes match no entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAYER_COUNT; k++) begin
				for (int c = 0; c < COLUMN_COUNT; c++) begin
					store_q[k][c] <= reset_level(k);
				end
			end
		end else if (wr) begin
			for (int k = 0; k < LAYER_COUNT; k++) begin
				for (int c = 0; c < COLUMN_COUNT; c++) begin
					if ((32'(item.layer_sel) == k) && (32'(item.column_sel) == c)) begin
						store_q[k][c] <= item.brightness_value;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/multiplexed_led_cube_pwm.sv =====
// a tick beat passes through the input register and then the output register, and may stall between them
// throughput: one beat per cycle while no tick stalls, writes and ticks alike; writes give no result
// writes keep draining from the input register while a result waits in the output register
// a tick stalls in the input register only while the output register is full and not taken
// reset: async active low; counter 255, layer 2, all columns high, all layers off
// reset: brightness layer 0 = 0, layer 1 = 125, others = 200, shadow values zero
module multiplexed_led_cube_pwm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mlcp_pkg::mlcp_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mlcp_pkg::mlcp_out_t out_data
);
	import mlcp_pkg::*;

	logic      valid_s1;
	mlcp_in_t  item_s1;
	logic      advance;
	logic      accept;
	mlcp_out_t result;

	// a write always leaves, a tick leaves when the output register frees
	assign advance  = valid_s1 && ((item_s1.req_type == REQ_WRITE) || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	mlcp_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && (item_s1.req_type == REQ_TICK)) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (item_s1.req_type == REQ_TICK)) begin
			out_data <= result;
		end
	end

endmodule

// ===== rtl/mlcp_checker.sv =====
// port-level checks for the led cube pwm driver, bound to the top level
module mlcp_assertions (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input mlcp_pkg::mlcp_in_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input mlcp_pkg::mlcp_out_t out_data
);
	import mlcp_pkg::*;

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// a stalled input beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input beat changed while stalled");

	// input side is open whenever the output register is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output register");

	// at most one layer driven low at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(out_data.layer_pins) >= 2)
		else $error("more than one layer active");

	// input side is open whenever the output side takes a beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked with output open");

endmodule

bind multiplexed_led_cube_pwm mlcp_assertions u_mlcp_assertions (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
